>>> rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared constants and types of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

	localparam int HUE_W  = 17;
	localparam int Q8_W   = 9;
	localparam int CH_W   = 8;
	localparam int REM_W  = 14;
	localparam int FRAC_W = 8;
	localparam int LVL_W  = 26;

	localparam logic [HUE_W-1:0] HUE_SECTOR = 17'd15360;
	localparam logic [HUE_W-1:0] HUE_FULL   = 17'd92160;
	localparam logic [Q8_W-1:0]  ONE_Q8     = 9'd256;

	// floor(rem / 60) == (rem * RECIP60) >> RECIP_SH for rem < 15360
	localparam int RECIP_W  = 15;
	localparam int RECIP_SH = 20;
	localparam logic [RECIP_W-1:0] RECIP60 = 15'd17477;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BRI = 2'd1;

	localparam logic [Q8_W-1:0] SAT_RESET = 9'd256;
	localparam logic [Q8_W-1:0] BRI_RESET = 9'd26;

	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	typedef struct packed {
		logic             grey;
		logic             black;
		sector_t          sector;
		logic [REM_W-1:0] rem;
	} hsv_item_t;

endpackage

>>> rtl/hsv_front.sv
// ----------------------------------------------------------------------------
// hsv_front
// Accepts hue items, unwraps 360 degrees and splits the hue into sector and
// remainder; flags grey and black items.
// ----------------------------------------------------------------------------
module hsv_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [hsv_pkg::HUE_W-1:0]  hue,
	input  logic                       sat_zero,
	output logic                       item_valid,
	output hsv_pkg::hsv_item_t         item,
	input  logic                       item_ready
);

	logic                      v_s1_q;
	hsv_pkg::hsv_item_t        item_s1;
	hsv_pkg::hsv_item_t        cls;
	logic [hsv_pkg::HUE_W-1:0] hue_w;
	logic [hsv_pkg::HUE_W-1:0] base;
	logic [3:0]                sec;
	logic                      accept;

	always_comb begin
		hue_w = (hue == hsv_pkg::HUE_FULL) ? '0 : hue;
		sec   = '0;
		base  = '0;
		for (int k = 1; k <= 8; k++) begin
			if (hue_w >= hsv_pkg::HUE_W'(k * int'(hsv_pkg::HUE_SECTOR))) begin
				sec  = 4'(k);
				base = hsv_pkg::HUE_W'(k * int'(hsv_pkg::HUE_SECTOR));
			end
		end
		cls.grey   = sat_zero;
		cls.black  = (sec > 4'd5);
		cls.sector = hsv_pkg::sector_t'(sec[2:0]);
		cls.rem    = hsv_pkg::REM_W'(hue_w - base);
	end

	assign full       = v_s1_q && !item_ready;
	assign accept     = push && !full;
	assign item_valid = v_s1_q;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (!v_s1_q || item_ready) begin
			v_s1_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cls;
		end
	end

`ifndef NO_ASSERTIONS
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1_q && !item_s1.black |-> item_s1.rem < hsv_pkg::REM_W'(hsv_pkg::HUE_SECTOR))
		else $error("front: remainder out of sector range");
`endif

endmodule

>>> rtl/hsv_queue.sv
// ----------------------------------------------------------------------------
// hsv_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module hsv_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	input  hsv_pkg::hsv_item_t wr_item,
	output logic               wr_ready,
	output logic               rd_valid,
	output hsv_pkg::hsv_item_t rd_item,
	input  logic               rd_pop
);

	hsv_pkg::hsv_item_t           mem [hsv_pkg::QDEPTH];
	logic [hsv_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [hsv_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [hsv_pkg::QCNT_W-1:0]   cnt_q;
	logic                         do_wr;
	logic                         do_rd;

	assign wr_ready = (cnt_q != hsv_pkg::QCNT_W'(hsv_pkg::QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_wr && do_rd) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= hsv_pkg::QCNT_W'(hsv_pkg::QDEPTH))
		else $error("queue: count above depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue: pointers differ while empty");
`endif

endmodule

>>> rtl/hsv_back.sv
// ----------------------------------------------------------------------------
// hsv_back
// Four-stage elastic pipeline: sector fraction, saturation products,
// brightness products, channel select and scaling to 8 bits.
// ----------------------------------------------------------------------------
module hsv_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  hsv_pkg::hsv_item_t         in_item,
	output logic                       in_pop,
	input  logic [hsv_pkg::Q8_W-1:0]   sat,
	input  logic [hsv_pkg::Q8_W-1:0]   bri,
	output logic                       empty,
	input  logic                       pop,
	output logic [hsv_pkg::CH_W-1:0]   red,
	output logic [hsv_pkg::CH_W-1:0]   green,
	output logic [hsv_pkg::CH_W-1:0]   blue
);

	localparam int PS_W = 17;
	localparam int AP_W = 17;

	function automatic logic [hsv_pkg::CH_W-1:0] to_channel(
		input logic [hsv_pkg::LVL_W-1:0] lvl);
		logic [hsv_pkg::LVL_W+7:0] t;
		t = {lvl, 8'd0} - (hsv_pkg::LVL_W+8)'(lvl);
		if (t[hsv_pkg::LVL_W+7:32] != '0) begin
			return '1;
		end
		return t[31:24];
	endfunction

	logic v1_q, v2_q, v3_q, v4_q;
	logic adv1, adv2, adv3, adv4;

	logic [hsv_pkg::Q8_W-1:0] sat_c;

	logic                                        grey_s1, black_s1;
	hsv_pkg::sector_t                            sec_s1;
	logic [hsv_pkg::FRAC_W-1:0]                  frac_s1;
	logic [hsv_pkg::REM_W+hsv_pkg::RECIP_W-1:0]  fprod;

	logic                     grey_s2, black_s2;
	hsv_pkg::sector_t         sec_s2;
	logic [PS_W-1:0]          ps_s2, pc_s2;
	logic [hsv_pkg::Q8_W-1:0] aam_s2;

	logic                       grey_s3, black_s3;
	hsv_pkg::sector_t           sec_s3;
	logic [hsv_pkg::LVL_W-1:0]  bb_s3, cc_s3;
	logic [AP_W-1:0]            ap_s3;

	logic [hsv_pkg::LVL_W-1:0] full_l, aa_l, r_l, g_l, b_l;
	logic [hsv_pkg::CH_W-1:0]  red_s4, green_s4, blue_s4;

	assign sat_c = (sat > hsv_pkg::ONE_Q8) ? hsv_pkg::ONE_Q8 : sat;

	assign adv4   = !v4_q || pop;
	assign adv3   = !v3_q || adv4;
	assign adv2   = !v2_q || adv3;
	assign adv1   = !v1_q || adv2;
	assign in_pop = in_valid && adv1;
	assign empty  = !v4_q;
	assign red    = red_s4;
	assign green  = green_s4;
	assign blue   = blue_s4;

	assign fprod = (hsv_pkg::REM_W+hsv_pkg::RECIP_W)'(in_item.rem)
		* (hsv_pkg::REM_W+hsv_pkg::RECIP_W)'(hsv_pkg::RECIP60);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= in_valid;
			if (adv2) v2_q <= v1_q;
			if (adv3) v3_q <= v2_q;
			if (adv4) v4_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			grey_s1  <= in_item.grey;
			black_s1 <= in_item.black;
			sec_s1   <= in_item.sector;
			frac_s1  <= fprod[hsv_pkg::RECIP_SH+hsv_pkg::FRAC_W-1:hsv_pkg::RECIP_SH];
		end
		if (adv2) begin
			grey_s2  <= grey_s1;
			black_s2 <= black_s1;
			sec_s2   <= sec_s1;
			ps_s2    <= PS_W'(sat_c) * PS_W'(frac_s1);
			pc_s2    <= PS_W'(sat_c) * PS_W'(hsv_pkg::ONE_Q8 - hsv_pkg::Q8_W'(frac_s1));
			aam_s2   <= hsv_pkg::ONE_Q8 - sat_c;
		end
		if (adv3) begin
			grey_s3  <= grey_s2;
			black_s3 <= black_s2;
			sec_s3   <= sec_s2;
			bb_s3    <= hsv_pkg::LVL_W'(bri) * hsv_pkg::LVL_W'(17'h10000 - ps_s2);
			cc_s3    <= hsv_pkg::LVL_W'(bri) * hsv_pkg::LVL_W'(17'h10000 - pc_s2);
			ap_s3    <= AP_W'(bri) * AP_W'(aam_s2);
		end
		if (adv4) begin
			red_s4   <= to_channel(r_l);
			green_s4 <= to_channel(g_l);
			blue_s4  <= to_channel(b_l);
		end
	end

	always_comb begin
		full_l = {1'b0, bri, 16'd0};
		aa_l   = {1'b0, ap_s3, 8'd0};
		r_l    = '0;
		g_l    = '0;
		b_l    = '0;
		if (grey_s3) begin
			r_l = full_l;
			g_l = full_l;
			b_l = full_l;
		end else if (!black_s3) begin
			unique case (sec_s3)
				hsv_pkg::SEC_RY: begin r_l = full_l; g_l = cc_s3;  b_l = aa_l;   end
				hsv_pkg::SEC_YG: begin r_l = bb_s3;  g_l = full_l; b_l = aa_l;   end
				hsv_pkg::SEC_GC: begin r_l = aa_l;   g_l = full_l; b_l = cc_s3;  end
				hsv_pkg::SEC_CB: begin r_l = aa_l;   g_l = bb_s3;  b_l = full_l; end
				hsv_pkg::SEC_BM: begin r_l = cc_s3;  g_l = aa_l;   b_l = full_l; end
				hsv_pkg::SEC_MR: begin r_l = full_l; g_l = aa_l;   b_l = bb_s3;  end
				default: begin r_l = '0; g_l = '0; b_l = '0; end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v4_q && !pop |=> v4_q && $stable(red_s4) && $stable(green_s4) && $stable(blue_s4))
		else $error("back: waiting result changed");
`endif

endmodule

>>> rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV to RGB conversion with hue per item and saturation / brightness
// set through configuration registers.
// ----------------------------------------------------------------------------
//   channel   handshake           payload
//   input     push / full         hue[16:0]
//   result    empty / pop         red[7:0], green[7:0], blue[7:0]
//   config    cfg_valid/ready     cfg_index[1:0], cfg_data[8:0]
//
// One item per cycle sustained while results are popped; a result passes the front
// register, the queue and the four back stages on its way to the ports.
// The back pipeline is made of its three multiply levels and the channel select.
// Reset clears all valid state; saturation and brightness return to 256 and 26.
// A stalled result side fills the back stages and the four-entry queue
// before full rises; config writes are taken every cycle.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [hsv_pkg::HUE_W-1:0]       hue,
	output logic                            empty,
	input  logic                            pop,
	output logic [hsv_pkg::CH_W-1:0]        red,
	output logic [hsv_pkg::CH_W-1:0]        green,
	output logic [hsv_pkg::CH_W-1:0]        blue,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hsv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hsv_pkg::Q8_W-1:0]        cfg_data
);

	logic [hsv_pkg::Q8_W-1:0] sat_q;
	logic [hsv_pkg::Q8_W-1:0] bri_q;

	logic               f_valid, f_ready;
	hsv_pkg::hsv_item_t f_item;
	logic               q_valid, q_pop;
	hsv_pkg::hsv_item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= hsv_pkg::SAT_RESET;
			bri_q <= hsv_pkg::BRI_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == hsv_pkg::CFG_SAT) begin
				sat_q <= cfg_data;
			end else if (cfg_index == hsv_pkg::CFG_BRI) begin
				bri_q <= cfg_data;
			end
		end
	end

	hsv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.hue        (hue),
		.sat_zero   (sat_q == '0),
		.item_valid (f_valid),
		.item       (f_item),
		.item_ready (f_ready)
	);

	hsv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_item  (f_item),
		.wr_ready (f_ready),
		.rd_valid (q_valid),
		.rd_item  (q_item),
		.rd_pop   (q_pop)
	);

	hsv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_item  (q_item),
		.in_pop   (q_pop),
		.sat      (sat_q),
		.bri      (bri_q),
		.empty    (empty),
		.pop      (pop),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

endmodule

>>> dv/hsv_to_rgb_converter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_test
// Self-checking bench for the HSV to RGB converter. Hues are fed through the
// push/full side from a backlog and every RGB triple popped is checked against
// a local predictor of the hexcone conversion. Saturation and brightness are
// reprogrammed between phases while the block is drained, covering grey,
// clamping, overdriven brightness, out-of-range hues and unused register
// indexes. Both sides idle in random bursts except in the last phase.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test;

	localparam int SETTLE_CYCLES = 12;
	localparam int STALL_LIMIT   = 1000;
	localparam int PHASE_ITEMS   = 130;
	localparam int FRAC_STEP     = 60;
	localparam int CH_MAX        = 255;
	localparam int LVL_SHIFT     = 24;
	localparam logic [hsv_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [hsv_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [hsv_pkg::CH_W-1:0] red;
		logic [hsv_pkg::CH_W-1:0] green;
		logic [hsv_pkg::CH_W-1:0] blue;
	} rgb_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          push      = 1'b0;
	logic [hsv_pkg::HUE_W-1:0]     hue       = '0;
	logic                          pop       = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic [hsv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [hsv_pkg::Q8_W-1:0]      cfg_data  = '0;
	logic                          full;
	logic                          empty;
	logic                          cfg_ready;
	logic [hsv_pkg::CH_W-1:0]      red;
	logic [hsv_pkg::CH_W-1:0]      green;
	logic [hsv_pkg::CH_W-1:0]      blue;

	logic [hsv_pkg::HUE_W-1:0] hue_backlog[$];
	rgb_t                      rgb_expected[$];
	logic [hsv_pkg::Q8_W-1:0]  sat_setting = hsv_pkg::SAT_RESET;
	logic [hsv_pkg::Q8_W-1:0]  bri_setting = hsv_pkg::BRI_RESET;
	bit                        calm = 1'b0;
	int                        send_gap = 0;
	int                        take_gap = 0;
	int                        quiet_cycles = 0;
	int                        hues_sent = 0;
	int                        pixels_checked = 0;
	int                        reg_writes = 0;
	int                        fail_count = 0;

	hsv_to_rgb_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.hue       (hue),
		.empty     (empty),
		.pop       (pop),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [hsv_pkg::CH_W-1:0] level_to_channel(
		input longint unsigned lvl);
		longint unsigned c;
		c = (lvl * 64'(CH_MAX)) >> LVL_SHIFT;
		return (c > 64'(CH_MAX)) ? CH_MAX[hsv_pkg::CH_W-1:0] : c[hsv_pkg::CH_W-1:0];
	endfunction

	function automatic rgb_t hsv_color(input logic [hsv_pkg::HUE_W-1:0] h);
		longint unsigned hv, sat, bri, peak, aa, bb, cc, frac, r, g, b, one;
		int              sec;
		rgb_t            px;
		one  = 64'(hsv_pkg::ONE_Q8);
		hv   = 64'(h);
		sat  = (sat_setting > hsv_pkg::ONE_Q8) ? one : 64'(sat_setting);
		bri  = 64'(bri_setting);
		peak = bri << 16;
		r = '0;
		g = '0;
		b = '0;
		if (sat == '0) begin
			r = peak;
			g = peak;
			b = peak;
		end else begin
			if (hv == 64'(hsv_pkg::HUE_FULL))
				hv = '0;
			sec  = int'(hv / 64'(hsv_pkg::HUE_SECTOR));
			frac = (hv % 64'(hsv_pkg::HUE_SECTOR)) / 64'(FRAC_STEP);
			aa   = (bri * (one - sat)) << 8;
			bb   = bri * (one * one - sat * frac);
			cc   = bri * (one * one - sat * (one - frac));
			case (sec)
				int'(hsv_pkg::SEC_RY): begin r = peak; g = cc;   b = aa;   end
				int'(hsv_pkg::SEC_YG): begin r = bb;   g = peak; b = aa;   end
				int'(hsv_pkg::SEC_GC): begin r = aa;   g = peak; b = cc;   end
				int'(hsv_pkg::SEC_CB): begin r = aa;   g = bb;   b = peak; end
				int'(hsv_pkg::SEC_BM): begin r = cc;   g = aa;   b = peak; end
				int'(hsv_pkg::SEC_MR): begin r = peak; g = aa;   b = bb;   end
				default: begin r = '0; g = '0; b = '0; end
			endcase
		end
		px.red   = level_to_channel(r);
		px.green = level_to_channel(g);
		px.blue  = level_to_channel(b);
		return px;
	endfunction

	// input side
	always @(negedge clk) begin
		logic go;
		go = arst_n && (hue_backlog.size() != 0);
		if (send_gap != 0) begin
			send_gap = send_gap - 1;
			go = 1'b0;
		end else if (!calm && $urandom_range(0, 15) == 0) begin
			send_gap = int'($urandom_range(1, 10)) - 1;
			go = 1'b0;
		end
		push <= go;
		if (go)
			hue <= hue_backlog[0];
	end

	// result side
	always @(negedge clk) begin
		logic take;
		take = arst_n;
		if (take_gap != 0) begin
			take_gap = take_gap - 1;
			take = 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			take_gap = int'($urandom_range(1, 10)) - 1;
			take = 1'b0;
		end
		pop <= take;
	end

	always @(posedge clk) begin
		rgb_t want;
		bit   moved;
		moved = 1'b0;
		if (arst_n) begin
			if (push && !full) begin
				rgb_expected.push_back(hsv_color(hue));
				void'(hue_backlog.pop_front());
				hues_sent++;
				moved = 1'b1;
			end
			if (pop && !empty) begin
				moved = 1'b1;
				if (rgb_expected.size() == 0) begin
					$error("unexpected pixel r=%0d g=%0d b=%0d", red, green, blue);
					fail_count++;
				end else begin
					want = rgb_expected.pop_front();
					if (red !== want.red) begin
						$error("red: expected %0d, got %0d", want.red, red);
						fail_count++;
					end
					if (green !== want.green) begin
						$error("green: expected %0d, got %0d", want.green, green);
						fail_count++;
					end
					if (blue !== want.blue) begin
						$error("blue: expected %0d, got %0d", want.blue, blue);
						fail_count++;
					end
					pixels_checked++;
				end
			end
			if (cfg_valid && cfg_ready)
				moved = 1'b1;
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic reg_write(input logic [hsv_pkg::CFG_IDX_W-1:0] idx,
			input logic [hsv_pkg::Q8_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == hsv_pkg::CFG_SAT)
			sat_setting = val;
		else if (idx == hsv_pkg::CFG_BRI)
			bri_setting = val;
		reg_writes++;
	endtask

	task automatic program_regs(input logic [hsv_pkg::Q8_W-1:0] sat,
			input logic [hsv_pkg::Q8_W-1:0] bri, input bit spare);
		if (spare)
			reg_write(CFG_SPARE_A, hsv_pkg::Q8_W'($urandom));
		reg_write(hsv_pkg::CFG_SAT, sat);
		reg_write(hsv_pkg::CFG_BRI, bri);
		if (spare)
			reg_write(CFG_SPARE_B, hsv_pkg::Q8_W'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_hues(input int n);
		logic [hsv_pkg::HUE_W-1:0] h;
		int                        k;
		int                        sec_w;
		sec_w = int'(hsv_pkg::HUE_SECTOR);
		repeat (n) begin
			k = int'($urandom_range(1, 6));
			case ($urandom_range(0, 9))
				7: begin
					case ($urandom_range(0, 2))
						0: h = hsv_pkg::HUE_FULL;
						1: h = hsv_pkg::HUE_W'(k * sec_w
							+ int'($urandom_range(0, 2)) - 1);
						default: h = hsv_pkg::HUE_W'((k - 1) * sec_w
							+ int'($urandom_range(0, 255)) * FRAC_STEP
							+ ($urandom_range(0, 1) != 0 ? FRAC_STEP - 1 : 0));
					endcase
				end
				8: h = hsv_pkg::HUE_W'($urandom_range(int'(hsv_pkg::HUE_FULL) + 1,
					2 ** hsv_pkg::HUE_W - 1));
				9: h = hsv_pkg::HUE_W'($urandom);
				default: h = hsv_pkg::HUE_W'($urandom_range(0,
					int'(hsv_pkg::HUE_FULL) - 1));
			endcase
			hue_backlog.push_back(h);
		end
	endtask

	task automatic settle();
		while (hue_backlog.size() != 0 || rgb_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [hsv_pkg::HUE_W-1:0] edge_hues[20];
		logic [hsv_pkg::Q8_W-1:0]  sat_plan[10];
		logic [hsv_pkg::Q8_W-1:0]  bri_plan[10];
		edge_hues = '{17'd0, 17'd1, 17'd59, 17'd60, 17'd15299, 17'd15300, 17'd15359,
			17'd15360, 17'd30720, 17'd46080, 17'd61440, 17'd76800, 17'd92159,
			17'd92160, 17'd92161, 17'd131071, 17'd7680, 17'd38400, 17'd65535,
			17'd100000};
		sat_plan = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd257, 9'd0, 9'd0, 9'd128, 9'd0, 9'd256};
		bri_plan = '{9'd256, 9'd256, 9'd511, 9'd1, 9'd0, 9'd0, 9'd0, 9'd300, 9'd0, 9'd26};
		sat_plan[6] = hsv_pkg::Q8_W'($urandom);
		bri_plan[6] = hsv_pkg::Q8_W'($urandom);
		sat_plan[8] = hsv_pkg::Q8_W'($urandom_range(1, 256));
		bri_plan[8] = hsv_pkg::Q8_W'($urandom_range(0, 256));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values of saturation and brightness first
		foreach (edge_hues[i])
			hue_backlog.push_back(edge_hues[i]);
		queue_hues(PHASE_ITEMS);
		settle();

		for (int p = 0; p < 10; p++) begin
			if (p == 9)
				calm = 1'b1;
			program_regs(sat_plan[p], bri_plan[p], p == 3 || p == 6);
			queue_hues(PHASE_ITEMS);
			settle();
		end

		if (rgb_expected.size() != 0) begin
			$error("%0d pixels never came out", rgb_expected.size());
			fail_count++;
		end
		$display("%0d hues sent, %0d pixels checked, %0d register writes over 11 settings",
			hues_sent, pixels_checked, reg_writes);
		$display("settings spanned grey, clamped saturation, overdriven and zero brightness");
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> files.f
rtl/hsv_pkg.sv
rtl/hsv_front.sv
rtl/hsv_queue.sv
rtl/hsv_back.sv
rtl/hsv_to_rgb_converter.sv
dv/hsv_to_rgb_converter_test.sv
